FILE: src/stst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stst_pkg: shared constants for the sleep timer slot table
// Field widths, opcodes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package stst_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int COUNT_BITS_DEF = 32;
  localparam int TASK_BITS_DEF  = 8;

  localparam int OPCODE_W = 2;
  localparam int TICKS_W  = 32;
  localparam int TASK_W   = 8;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 3;
  localparam int STAMP_W  = 64;

  localparam logic [OPCODE_W-1:0] OP_ARM    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ARMED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ARMED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TICK      = 3'd4;

endpackage
`default_nettype wire

FILE: src/sleep_timer_slot_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sleep_timer_slot_table: table of one-shot sleep timers
// Arm, cancel and tick items over a RAM of per-slot counters and task ids.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_stall is high until its last result is
// in the output register. Tick counts and task ids live in one RAM with a
// registered read; armed flags are flip-flops cleared by reset, so no clearing
// pass is needed. An arm scans the armed flags one slot per cycle and takes
// the lowest free slot, or reports the table full after the last slot. A
// cancel needs no scan. A tick walks every slot: a free slot is skipped, an
// armed one is read from the RAM and then written back. A stall on the result
// channel holds the walk whenever a woken task must leave before the next one
// is found.
module sleep_timer_slot_table #(
  parameter int SLOTS      = stst_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = stst_pkg::COUNT_BITS_DEF,
  parameter int TASK_BITS  = stst_pkg::TASK_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [stst_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [stst_pkg::TICKS_W-1:0]  in_sleep_ticks,
  input  wire logic [stst_pkg::TASK_W-1:0]   in_task_id,
  input  wire logic [stst_pkg::SLOT_W-1:0]   in_slot,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [stst_pkg::STATUS_W-1:0] out_status,
  output      logic [stst_pkg::SLOT_W-1:0]   out_slot_index,
  output      logic [stst_pkg::TASK_W-1:0]   out_woken_task,
  output      logic                          out_woke_valid,
  output      logic [stst_pkg::STAMP_W-1:0]  out_tick_count,
  output      logic                          out_last
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int ENT_W = COUNT_BITS + TASK_BITS;
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);
  localparam logic [15:0]      SLOTS_W16 = 16'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARM,
    S_TICK_RD,
    S_TICK_WB,
    S_TICK_END,
    S_OUT
  } state_t;

  state_t state_r;

  logic [SLOTS-1:0]                armed_r;
  logic [IDX_W-1:0]                idx_r;
  logic [stst_pkg::STAMP_W-1:0]    tick_cnt_r;
  logic [COUNT_BITS-1:0]           arg_ticks_r;
  logic [TASK_BITS-1:0]            arg_task_r;
  logic [stst_pkg::STATUS_W-1:0]   res_status_r;
  logic [stst_pkg::SLOT_W-1:0]     res_slot_r;
  logic                            pend_valid_r;
  logic [IDX_W-1:0]                pend_slot_r;
  logic [TASK_BITS-1:0]            pend_task_r;

  logic                            out_valid_r;
  logic [stst_pkg::STATUS_W-1:0]   out_status_r;
  logic [stst_pkg::SLOT_W-1:0]     out_slot_index_r;
  logic [stst_pkg::TASK_W-1:0]     out_woken_task_r;
  logic                            out_woke_valid_r;
  logic [stst_pkg::STAMP_W-1:0]    out_tick_count_r;
  logic                            out_last_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic                  idx_at_last;
  logic [COUNT_BITS-1:0] arm_ticks;
  logic [IDX_W-1:0]      cancel_idx;
  logic                  cancel_hit;

  logic                  ram_wr_en;
  logic [ENT_W-1:0]      ram_wr_data;
  logic                  ram_rd_en;
  logic [ENT_W-1:0]      ram_rd_data;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [TASK_BITS-1:0]  rd_task;
  logic [COUNT_BITS-1:0] dec_cnt;
  logic                  expire;
  logic                  wb_hold;

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign idx_at_last = (idx_r == IDX_LAST);

  // a count of zero arms for one tick
  assign arm_ticks  = (COUNT_BITS'(in_sleep_ticks) == '0) ? COUNT_BITS'(1)
                                                          : COUNT_BITS'(in_sleep_ticks);
  assign cancel_idx = IDX_W'(in_slot);
  assign cancel_hit = (16'(in_slot) < SLOTS_W16) && armed_r[cancel_idx];

  assign rd_cnt  = ram_rd_data[ENT_W-1:TASK_BITS];
  assign rd_task = ram_rd_data[TASK_BITS-1:0];
  assign dec_cnt = rd_cnt - COUNT_BITS'(1);
  assign expire  = (dec_cnt == '0);
  // a second wake cannot be staged while the previous one still waits
  assign wb_hold = expire && pend_valid_r && !out_free;

  // a new item enters the output register this cycle
  assign out_load = (state_r == S_TICK_WB && !wb_hold && expire && pend_valid_r) ||
                    ((state_r == S_TICK_END || state_r == S_OUT) && out_free);

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_data = {dec_cnt, rd_task};
    ram_rd_en   = 1'b0;
    case (state_r)
      S_ARM: begin
        ram_wr_en   = !armed_r[idx_r];
        ram_wr_data = {arg_ticks_r, arg_task_r};
      end
      S_TICK_RD: begin
        ram_rd_en = armed_r[idx_r];
      end
      S_TICK_WB: begin
        ram_wr_en = !wb_hold;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  stst_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      armed_r      <= '0;
      tick_cnt_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_opcode)
              stst_pkg::OP_ARM: begin
                arg_ticks_r <= arm_ticks;
                arg_task_r  <= TASK_BITS'(in_task_id);
                idx_r       <= '0;
                state_r     <= S_ARM;
              end
              stst_pkg::OP_CANCEL: begin
                res_slot_r <= in_slot;
                if (cancel_hit) begin
                  armed_r[cancel_idx] <= 1'b0;
                  res_status_r        <= stst_pkg::ST_CANCELLED;
                end else begin
                  res_status_r <= stst_pkg::ST_NOT_ARMED;
                end
                state_r <= S_OUT;
              end
              stst_pkg::OP_TICK: begin
                tick_cnt_r   <= tick_cnt_r + stst_pkg::STAMP_W'(1);
                idx_r        <= '0;
                pend_valid_r <= 1'b0;
                state_r      <= S_TICK_RD;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_ARM: begin
          if (!armed_r[idx_r]) begin
            armed_r[idx_r] <= 1'b1;
            res_status_r   <= stst_pkg::ST_ARMED;
            res_slot_r     <= stst_pkg::SLOT_W'(idx_r);
            state_r        <= S_OUT;
          end else if (idx_at_last) begin
            res_status_r <= stst_pkg::ST_FULL;
            res_slot_r   <= '0;
            state_r      <= S_OUT;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_TICK_RD: begin
          if (armed_r[idx_r]) begin
            state_r <= S_TICK_WB;
          end else if (idx_at_last) begin
            state_r <= S_TICK_END;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        S_TICK_WB: begin
          if (!wb_hold) begin
            if (expire) begin
              armed_r[idx_r] <= 1'b0;
              // release the previous wake; this one may still be the last
              if (pend_valid_r) begin
                out_status_r     <= stst_pkg::ST_TICK;
                out_slot_index_r <= stst_pkg::SLOT_W'(pend_slot_r);
                out_woken_task_r <= stst_pkg::TASK_W'(pend_task_r);
                out_woke_valid_r <= 1'b1;
                out_tick_count_r <= tick_cnt_r;
                out_last_r       <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_slot_r  <= idx_r;
              pend_task_r  <= rd_task;
            end
            if (idx_at_last) begin
              state_r <= S_TICK_END;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= S_TICK_RD;
            end
          end
        end
        S_TICK_END: begin
          if (out_free) begin
            out_status_r     <= stst_pkg::ST_TICK;
            out_tick_count_r <= tick_cnt_r;
            out_last_r       <= 1'b1;
            out_woke_valid_r <= pend_valid_r;
            if (pend_valid_r) begin
              out_slot_index_r <= stst_pkg::SLOT_W'(pend_slot_r);
              out_woken_task_r <= stst_pkg::TASK_W'(pend_task_r);
            end else begin
              out_slot_index_r <= '0;
              out_woken_task_r <= '0;
            end
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_status_r     <= res_status_r;
            out_slot_index_r <= res_slot_r;
            out_woken_task_r <= '0;
            out_woke_valid_r <= 1'b0;
            out_tick_count_r <= tick_cnt_r;
            out_last_r       <= 1'b1;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_index_r;
  assign out_woken_task = out_woken_task_r;
  assign out_woke_valid = out_woke_valid_r;
  assign out_tick_count = out_tick_count_r;
  assign out_last       = out_last_r;

  a_tick_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode == stst_pkg::OP_TICK) |=> (tick_cnt_r == $past(tick_cnt_r) + 64'd1))
    else $error("tick counter did not advance on a tick item");

  a_pend_in_tick : assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == S_TICK_RD || state_r == S_TICK_WB || state_r == S_TICK_END))
    else $error("staged wake outside a tick walk");

  a_wb_armed : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK_WB) |-> armed_r[idx_r])
    else $error("write back to a free slot");

  a_mid_is_wake : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_woke_valid_r && out_status_r == stst_pkg::ST_TICK))
    else $error("non-final result that is not a wake");

endmodule
`default_nettype wire

FILE: src/stst_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stst_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data when no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire
